// File: hdl/rtc3w_pkg.sv
package rtc3w_pkg;

    // burst address, space sizes, last ram offset and reject byte of the clock chip
    localparam logic [4:0] BURST_ADDR      = 5'd31;
    localparam logic [4:0] RAM_BYTES       = 5'd31;
    localparam logic [4:0] CLOCK_BYTES     = 5'd8;
    localparam logic [4:0] RAM_LAST_OFFSET = 5'd30;
    localparam logic [7:0] REJECT_BYTE     = 8'hEE;

    localparam int QUEUE_DEPTH = 2;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_START  = 2'd1,
        OP_SUPPLY = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CMD  = 3'd1,
        PH_WAIT = 3'd2,
        PH_SEND = 3'd3,
        PH_RECV = 3'd4,
        PH_END  = 3'd5
    } phase_t;

    // one classified word as it waits in the queue
    typedef struct packed {
        op_t        kind;
        logic [7:0] cmd_byte;
        logic [4:0] byte_total;
        logic       reject;
        logic       is_read;
        logic [7:0] write_byte;
        logic       io_in;
    } item_t;

    typedef struct packed {
        logic       ce_pin;
        logic       sclk_pin;
        logic       io_out;
        logic       io_drive;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_byte;
        logic       busy_res;
        logic       done_res;
    } result_t;

endpackage

// File: hdl/rtc3w_front.sv
module rtc3w_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rtc3w_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                              queue_full,
    output logic                              push,
    output rtc3w_pkg::item_t                  item
);
    import rtc3w_pkg::*;

    logic [1:0] operation;
    logic [4:0] req_address;
    logic       ram_space;
    logic       is_read;
    logic       is_burst;
    logic [4:0] byte_count;
    logic [5:0] cmd_addr;
    logic [4:0] burst_len;

    assign operation   = s_tdata[1:0];
    assign req_address = s_tdata[6:2];
    assign ram_space   = s_tdata[7];
    assign is_read     = s_tdata[8];
    assign is_burst    = s_tdata[9];
    assign byte_count  = s_tdata[14:10];

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb begin
        if (ram_space) begin
            burst_len = (byte_count < RAM_BYTES) ? byte_count : RAM_BYTES;
        end else begin
            burst_len = (byte_count < CLOCK_BYTES) ? byte_count : CLOCK_BYTES;
        end
    end

    assign cmd_addr = is_burst ? {ram_space, BURST_ADDR} : {ram_space, req_address};

    always_comb begin
        unique case (operation)
            OP_START:  item.kind = OP_START;
            OP_SUPPLY: item.kind = OP_SUPPLY;
            default:   item.kind = OP_TICK;
        endcase
        item.cmd_byte   = {1'b1, cmd_addr, is_read};
        item.byte_total = is_burst ? burst_len : 5'd1;
        // single ram access past the last offset is refused
        item.reject     = !is_burst && ram_space && (req_address > RAM_LAST_OFFSET);
        item.is_read    = is_read;
        item.write_byte = s_tdata[22:15];
        item.io_in      = s_tdata[23];
    end

endmodule

// File: hdl/rtc3w_queue.sv
module rtc3w_queue #(
    parameter int DEPTH = rtc3w_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rtc3w_pkg::item_t  push_item,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output rtc3w_pkg::item_t  head
);
    import rtc3w_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = (count_reg == CNT_FULL);
    assign valid  = (count_reg != '0);
    assign head   = entry_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count above depth");

    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

// File: hdl/rtc3w_engine.sv
module rtc3w_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    input  rtc3w_pkg::item_t     item,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rtc3w_pkg::result_t   result
);
    import rtc3w_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic [4:0] bytes_left_reg, bytes_left_next;
    logic       reading_reg, reading_next;
    logic [1:0] sub_step_reg, sub_step_next;
    logic       ce_reg, ce_next;
    logic       sclk_reg, sclk_next;
    logic       io_reg, io_next;
    logic       drive_reg, drive_next;
    logic       m_valid_reg;
    result_t    result_reg, result_next;

    logic       fire;
    logic       last_bit;
    logic [4:0] bytes_dec;
    logic [4:0] bytes_after_send;
    logic [7:0] recv_bits;
    logic       start_ok;

    assign fire     = item_valid && (!m_valid_reg || m_ready);
    assign pop      = fire;
    assign m_valid  = m_valid_reg;
    assign result   = result_reg;

    assign last_bit         = (bit_index_reg == 3'd7);
    assign bytes_dec        = bytes_left_reg - 5'd1;
    assign bytes_after_send = (phase_reg == PH_SEND) ? bytes_dec : bytes_left_reg;
    assign recv_bits        = shift_reg | (8'(item.io_in) << bit_index_reg);
    assign start_ok         = (item.kind == OP_START) && !item.reject;

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (fire) begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (start_ok) begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD, PH_SEND: begin
                    if (sub_step_reg == 2'd1) begin
                        // a read command ends on the rising edge of its last bit
                        if (phase_reg == PH_CMD && reading_reg && last_bit) begin
                            phase_next = (bytes_left_reg == '0) ? PH_END : PH_RECV;
                        end
                    end else if (sub_step_reg != 2'd0) begin
                        if (last_bit) begin
                            phase_next = (bytes_after_send == '0) ? PH_END : PH_WAIT;
                        end
                    end
                end
                PH_WAIT: begin
                    if (item.kind == OP_SUPPLY) begin
                        phase_next = PH_SEND;
                    end
                end
                PH_RECV: begin
                    if (sub_step_reg != 2'd0 && sub_step_reg != 2'd1 && last_bit) begin
                        phase_next = (bytes_dec == '0) ? PH_END : PH_RECV;
                    end
                end
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        bytes_left_next = bytes_left_reg;
        reading_next    = reading_reg;
        sub_step_next   = sub_step_reg;
        ce_next         = ce_reg;
        sclk_next       = sclk_reg;
        io_next         = io_reg;
        drive_next      = drive_reg;
        result_next     = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (item.kind == OP_START) begin
                    if (item.reject) begin
                        result_next.done_res   = 1'b1;
                        result_next.read_valid = item.is_read;
                        result_next.read_byte  = item.is_read ? REJECT_BYTE : 8'd0;
                    end else begin
                        bytes_left_next = item.byte_total;
                        reading_next    = item.is_read;
                        shift_next      = item.cmd_byte;
                        bit_index_next  = '0;
                        sub_step_next   = '0;
                        ce_next         = 1'b1;
                    end
                end
            end
            PH_CMD, PH_SEND: begin
                if (sub_step_reg == 2'd0) begin
                    drive_next    = 1'b1;
                    io_next       = shift_reg[0];
                    sub_step_next = 2'd1;
                end else if (sub_step_reg == 2'd1) begin
                    sclk_next = 1'b1;
                    if (phase_reg == PH_CMD && reading_reg && last_bit) begin
                        if (bytes_left_reg != '0) begin
                            sub_step_next  = '0;
                            bit_index_next = '0;
                            shift_next     = '0;
                        end
                    end else begin
                        sub_step_next = 2'd2;
                    end
                end else begin
                    sclk_next  = 1'b0;
                    shift_next = {1'b0, shift_reg[7:1]};
                    if (last_bit) begin
                        bytes_left_next = bytes_after_send;
                        if (bytes_after_send != '0) begin
                            sub_step_next  = '0;
                            bit_index_next = '0;
                        end
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        sub_step_next  = '0;
                    end
                end
            end
            PH_WAIT: begin
                if (item.kind == OP_SUPPLY) begin
                    shift_next     = item.write_byte;
                    bit_index_next = '0;
                    sub_step_next  = '0;
                end
            end
            PH_RECV: begin
                if (sub_step_reg == 2'd0) begin
                    drive_next    = 1'b0;
                    sclk_next     = 1'b1;
                    sub_step_next = 2'd1;
                end else if (sub_step_reg == 2'd1) begin
                    sclk_next     = 1'b0;
                    sub_step_next = 2'd2;
                end else begin
                    shift_next = recv_bits;
                    if (last_bit) begin
                        result_next.read_byte  = recv_bits;
                        result_next.read_valid = 1'b1;
                        bytes_left_next        = bytes_dec;
                        if (bytes_dec != '0) begin
                            sub_step_next  = '0;
                            bit_index_next = '0;
                            shift_next     = '0;
                        end
                    end else begin
                        bit_index_next = bit_index_reg + 3'd1;
                        sub_step_next  = '0;
                    end
                end
            end
            default: begin
                drive_next           = 1'b1;
                sclk_next            = 1'b0;
                ce_next              = 1'b0;
                sub_step_next        = '0;
                bit_index_next       = '0;
                result_next.done_res = 1'b1;
            end
        endcase

        result_next.ce_pin    = ce_next;
        result_next.sclk_pin  = sclk_next;
        result_next.io_out    = io_next;
        result_next.io_drive  = drive_next;
        result_next.need_byte = (phase_next == PH_WAIT);
        result_next.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            bit_index_reg  <= '0;
            shift_reg      <= '0;
            bytes_left_reg <= '0;
            reading_reg    <= 1'b0;
            sub_step_reg   <= '0;
            ce_reg         <= 1'b0;
            sclk_reg       <= 1'b0;
            io_reg         <= 1'b0;
            drive_reg      <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg      <= phase_next;
                bit_index_reg  <= bit_index_next;
                shift_reg      <= shift_next;
                bytes_left_reg <= bytes_left_next;
                reading_reg    <= reading_next;
                sub_step_reg   <= sub_step_next;
                ce_reg         <= ce_next;
                sclk_reg       <= sclk_next;
                io_reg         <= io_next;
                drive_reg      <= drive_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_ce_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> !ce_reg)
        else $error("chip enable high while idle");

    a_recv_released: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_RECV && sub_step_reg != 2'd0) |-> !drive_reg)
        else $error("data pin driven during a read bit");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.done_res) |-> !result_reg.busy_res)
        else $error("finished word still reports busy");
`endif

endmodule

// File: hdl/rtc_three_wire_serial_master.sv
// a word accepted on s_tdata waits in the queue, and its result is registered before it shows on m_tdata
// throughput: one word per cycle while m_tready lets results drain; each word moves at most one pin event
// the output register and a two-entry queue let input and output stall apart
// reset: synchronous, active low; sequencer idle, counters cleared, queue emptied
// reset pin levels: chip enable, clock and data low, data pin driven
module rtc_three_wire_serial_master #(
    parameter int QUEUE_DEPTH = rtc3w_pkg::QUEUE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0] req_address[6:2] ram_space[7] is_read[8] is_burst[9]
    // byte_count[14:10] write_byte[22:15] io_in[23]
    input  logic [rtc3w_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ce_pin[0] sclk_pin[1] io_out[2] io_drive[3] read_byte[11:4]
    // read_valid[12] need_byte[13] busy_res[14], zero pad[15]
    output logic [rtc3w_pkg::M_DATA_W-1:0]    m_tdata,
    // done_res
    output logic                              m_tlast
);
    import rtc3w_pkg::*;

    logic    push;
    logic    queue_full;
    logic    queue_valid;
    logic    pop;
    item_t   front_item;
    item_t   head_item;
    result_t res;

    rtc3w_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .push       (push),
        .item       (front_item)
    );

    rtc3w_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (pop),
        .valid     (queue_valid),
        .head      (head_item)
    );

    rtc3w_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (queue_valid),
        .item       (head_item),
        .pop        (pop),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .result     (res)
    );

    assign m_tdata = {1'b0, res.busy_res, res.need_byte, res.read_valid, res.read_byte,
                      res.io_drive, res.io_out, res.sclk_pin, res.ce_pin};
    assign m_tlast = res.done_res;

endmodule

// File: dv/rtc_three_wire_serial_master_checker.sv
module rtc_three_wire_serial_master_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [rtc3w_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rtc3w_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                              m_tlast,
    output int                                errors,
    output int                                pending,
    output int                                checked,
    output int                                bytes_read,
    output int                                closes
);
    import rtc3w_pkg::*;

    // sequencer copy
    phase_t     seq_phase;
    logic [2:0] seq_bit;
    logic [7:0] seq_shift;
    logic [4:0] seq_left;
    logic       seq_reading;
    logic [1:0] seq_sub;
    logic       pin_ce, pin_sclk, pin_io, pin_drive;

    result_t pending_events[$];

    function automatic void clear_engine();
        seq_phase   = PH_IDLE;
        seq_bit     = '0;
        seq_shift   = '0;
        seq_left    = '0;
        seq_reading = 1'b0;
        seq_sub     = '0;
        pin_ce      = 1'b0;
        pin_sclk    = 1'b0;
        pin_io      = 1'b0;
        pin_drive   = 1'b1;
    endfunction

    function automatic void start_rx_byte();
        seq_phase = PH_RECV;
        seq_sub   = '0;
        seq_bit   = '0;
        seq_shift = '0;
    endfunction

    // advance one pin event for an accepted word and give the pins after it
    function automatic result_t next_pin_event(logic [S_DATA_W-1:0] w);
        logic [1:0] op;
        logic [4:0] addr;
        logic       ram;
        logic       rd;
        logic       burst;
        logic [4:0] cnt;
        logic [7:0] wbyte;
        logic       io_in;
        logic [5:0] cmd_addr;
        logic       launch;
        result_t    r;
        op     = w[1:0];
        addr   = w[6:2];
        ram    = w[7];
        rd     = w[8];
        burst  = w[9];
        cnt    = w[14:10];
        wbyte  = w[22:15];
        io_in  = w[23];
        r      = '0;
        launch = 1'b0;
        cmd_addr = '0;
        case (seq_phase)
            PH_IDLE: begin
                if (op == OP_START) begin
                    if (burst) begin
                        cmd_addr = {ram, BURST_ADDR};
                        if (ram)
                            seq_left = (cnt < RAM_BYTES) ? cnt : RAM_BYTES;
                        else
                            seq_left = (cnt < CLOCK_BYTES) ? cnt : CLOCK_BYTES;
                        launch = 1'b1;
                    end else if (ram && addr > RAM_LAST_OFFSET) begin
                        // offset past the end of ram: nothing goes on the pins
                        r.done_res = 1'b1;
                        if (rd) begin
                            r.read_byte  = REJECT_BYTE;
                            r.read_valid = 1'b1;
                        end
                    end else begin
                        cmd_addr = {ram, addr};
                        seq_left = 5'd1;
                        launch   = 1'b1;
                    end
                    if (launch) begin
                        seq_reading = rd;
                        seq_shift   = {1'b1, cmd_addr, rd};
                        seq_bit     = '0;
                        seq_sub     = '0;
                        pin_ce      = 1'b1;
                        seq_phase   = PH_CMD;
                    end
                end
            end
            PH_CMD, PH_SEND: begin
                if (seq_sub == 2'd0) begin
                    pin_drive = 1'b1;
                    pin_io    = seq_shift[0];
                    seq_sub   = 2'd1;
                end else if (seq_sub == 2'd1) begin
                    pin_sclk = 1'b1;
                    // read command: the last falling edge belongs to the first read bit
                    if (seq_phase == PH_CMD && seq_reading && seq_bit == 3'd7) begin
                        if (seq_left == 0)
                            seq_phase = PH_END;
                        else
                            start_rx_byte();
                    end else begin
                        seq_sub = 2'd2;
                    end
                end else begin
                    pin_sclk  = 1'b0;
                    seq_shift = seq_shift >> 1;
                    if (seq_bit == 3'd7) begin
                        if (seq_phase == PH_SEND)
                            seq_left = seq_left - 5'd1;
                        if (seq_left == 0) begin
                            seq_phase = PH_END;
                        end else begin
                            seq_phase = PH_WAIT;
                            seq_sub   = '0;
                            seq_bit   = '0;
                        end
                    end else begin
                        seq_bit = seq_bit + 3'd1;
                        seq_sub = '0;
                    end
                end
            end
            PH_WAIT: begin
                if (op == OP_SUPPLY) begin
                    seq_shift = wbyte;
                    seq_bit   = '0;
                    seq_sub   = '0;
                    seq_phase = PH_SEND;
                end
            end
            PH_RECV: begin
                if (seq_sub == 2'd0) begin
                    pin_drive = 1'b0;
                    pin_sclk  = 1'b1;
                    seq_sub   = 2'd1;
                end else if (seq_sub == 2'd1) begin
                    pin_sclk = 1'b0;
                    seq_sub  = 2'd2;
                end else begin
                    seq_shift = seq_shift | (8'(io_in) << seq_bit);
                    if (seq_bit == 3'd7) begin
                        r.read_byte  = seq_shift;
                        r.read_valid = 1'b1;
                        seq_left     = seq_left - 5'd1;
                        if (seq_left == 0)
                            seq_phase = PH_END;
                        else
                            start_rx_byte();
                    end else begin
                        seq_bit = seq_bit + 3'd1;
                        seq_sub = '0;
                    end
                end
            end
            default: begin
                pin_drive  = 1'b1;
                pin_sclk   = 1'b0;
                pin_ce     = 1'b0;
                seq_phase  = PH_IDLE;
                seq_sub    = '0;
                seq_bit    = '0;
                r.done_res = 1'b1;
            end
        endcase
        r.ce_pin    = pin_ce;
        r.sclk_pin  = pin_sclk;
        r.io_out    = pin_io;
        r.io_drive  = pin_drive;
        r.need_byte = (seq_phase == PH_WAIT);
        r.busy_res  = (seq_phase != PH_IDLE);
        return r;
    endfunction

    function automatic void cmp_field(string fname, int want_v, int got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", fname, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            clear_engine();
            pending_events.delete();
            errors     = 0;
            checked    = 0;
            bytes_read = 0;
            closes     = 0;
        end else begin
            // compare first so a word can never match its own edge
            if (m_tvalid && m_tready) begin
                if (pending_events.size() == 0) begin
                    $error("result word with nothing pending: m_tdata %h", m_tdata);
                    errors++;
                end else begin
                    want = pending_events.pop_front();
                    cmp_field("ce_pin", want.ce_pin, m_tdata[0]);
                    cmp_field("sclk_pin", want.sclk_pin, m_tdata[1]);
                    cmp_field("io_out", want.io_out, m_tdata[2]);
                    cmp_field("io_drive", want.io_drive, m_tdata[3]);
                    cmp_field("read_byte", want.read_byte, m_tdata[11:4]);
                    cmp_field("read_valid", want.read_valid, m_tdata[12]);
                    cmp_field("need_byte", want.need_byte, m_tdata[13]);
                    cmp_field("busy_res", want.busy_res, m_tdata[14]);
                    cmp_field("done_res", want.done_res, m_tlast);
                    checked++;
                    if (want.read_valid)
                        bytes_read++;
                    if (want.done_res)
                        closes++;
                end
            end
            if (s_tvalid && s_tready)
                pending_events.push_back(next_pin_event(s_tdata));
        end
        pending = pending_events.size();
    end

endmodule

// File: dv/rtc_three_wire_serial_master_tb.sv
module rtc_three_wire_serial_master_tb;
    import rtc3w_pkg::*;

    localparam int WORD_TARGET = 1050;
    localparam int TAIL_FROM   = 950;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 48;
    localparam int QUIET_LIMIT = 2000;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tlast;

    int errors, pending, checked, bytes_read, closes;
    int words_sent   = 0;
    int quiet_cycles = 0;
    bit gaps_on      = 1'b1;
    bit hold_done    = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    rtc_three_wire_serial_master i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    rtc_three_wire_serial_master_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .errors     (errors),
        .pending    (pending),
        .checked    (checked),
        .bytes_read (bytes_read),
        .closes     (closes)
    );

    // s_tdata: operation[1:0] req_address[6:2] ram_space[7] is_read[8] is_burst[9]
    // byte_count[14:10] write_byte[22:15] io_in[23]
    function automatic logic [S_DATA_W-1:0] pack_word(logic [1:0] op, logic [4:0] addr,
                                                      logic ram, logic rd, logic burst,
                                                      logic [4:0] cnt, logic [7:0] wbyte,
                                                      logic io_in);
        return {io_in, wbyte, cnt, burst, rd, ram, addr, op};
    endfunction

    function automatic logic [S_DATA_W-1:0] noise_word(logic [1:0] op);
        logic [S_DATA_W-1:0] w;
        w = S_DATA_W'($urandom);
        w[1:0] = op;
        return w;
    endfunction

    // mostly ticks and write bytes, now and then op 3 or a start that must be ignored
    function automatic logic [S_DATA_W-1:0] follow_word();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)
            return noise_word(OP_TICK);
        else if (pick < 18)
            return noise_word(OP_SUPPLY);
        else if (pick == 18)
            return noise_word(2'd3);
        else
            return noise_word(OP_START);
    endfunction

    task automatic send_word(input logic [S_DATA_W-1:0] w);
        if (gaps_on && words_sent < TAIL_FROM && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    task automatic run_transaction(input bit big);
        logic       ram, rd, burst;
        logic [4:0] addr, cnt;
        int         pick, nbytes, follow;
        ram   = $urandom_range(0, 1);
        rd    = $urandom_range(0, 1);
        burst = $urandom_range(0, 1);
        addr  = $urandom_range(0, 31);
        cnt   = $urandom_range(0, 31);
        pick  = $urandom_range(0, 9);
        gaps_on = ($urandom_range(0, 3) != 0);
        if (big) begin
            // longest ram burst, read back to keep the run short
            ram = 1'b1; rd = 1'b1; burst = 1'b1; cnt = 5'd31;
        end else if (burst && ram) begin
            cnt = $urandom_range(0, 4);
        end else if (burst && pick < 7) begin
            cnt = $urandom_range(0, 3);
        end else if (!burst && ram && pick < 3) begin
            addr = (pick == 0) ? 5'd31 : 5'd30;
        end
        if (burst)
            nbytes = ram ? cnt : ((cnt < CLOCK_BYTES) ? cnt : CLOCK_BYTES);
        else
            nbytes = 1;
        if (!burst && ram && addr > RAM_LAST_OFFSET)
            follow = 0;
        else
            follow = 26 + nbytes * (rd ? 25 : 32);
        // a cut-short sequence now and then
        if (!big && $urandom_range(0, 9) == 0)
            follow = follow / 2;
        send_word(pack_word(OP_START, addr, ram, rd, burst, cnt,
                            8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
        repeat (follow) send_word(follow_word());
    endtask

    // result side: short random stalls, one long hold-off while words keep coming
    initial begin
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!hold_done && words_sent >= HOLD_AT) begin
                m_tready  <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (words_sent < TAIL_FROM && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** rtc_three_wire_serial_master: FAILED **");
            $finish;
        end
    end

    initial begin
        int txn;
        int pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle words with extreme fields, all ignored
        send_word(pack_word(OP_TICK, 5'd0, 1'b0, 1'b0, 1'b0, 5'd0, 8'h00, 1'b0));
        send_word({S_DATA_W{1'b1}});
        send_word(pack_word(OP_SUPPLY, 5'd31, 1'b1, 1'b1, 1'b1, 5'd31, 8'hFF, 1'b1));
        // ram offset past the end, read then write
        send_word(pack_word(OP_START, 5'd31, 1'b1, 1'b1, 1'b0, 5'd0, 8'h00, 1'b1));
        send_word(pack_word(OP_START, 5'd31, 1'b1, 1'b0, 1'b0, 5'd31, 8'hFF, 1'b0));
        // zero-length clock burst read: command only, then close
        send_word(pack_word(OP_START, 5'd0, 1'b0, 1'b1, 1'b1, 5'd0, 8'hA5, 1'b0));
        for (int i = 0; i < 24; i++) begin
            if (i == 5)
                send_word(pack_word(OP_START, 5'd3, 1'b0, 1'b0, 1'b0, 5'd1, 8'h5A, 1'b1));
            else if (i == 9)
                send_word(pack_word(OP_SUPPLY, 5'd0, 1'b0, 1'b0, 1'b0, 5'd0, 8'hC3, 1'b1));
            else
                send_word(noise_word(OP_TICK));
        end

        txn = 0;
        while (words_sent < WORD_TARGET) begin
            pick = $urandom_range(0, 19);
            if (txn == 4) begin
                run_transaction(1'b1);
            end else if (pick < 3) begin
                repeat ($urandom_range(1, 6))
                    send_word(noise_word(2'($urandom_range(0, 3))));
            end else begin
                run_transaction(1'b0);
            end
            txn++;
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("covered %0d input words in %0d transactions, %0d result words checked",
                 words_sent, txn, checked);
        $display("%0d bytes read back, %0d transactions closed, one long output stall",
                 bytes_read, closes);
        if (errors == 0) begin
            $display("** rtc_three_wire_serial_master: PASSED **");
        end else begin
            $display("** rtc_three_wire_serial_master: FAILED **");
        end
        $finish;
    end

endmodule
